/* hw/rtl/flstat_pkg.sv */
package flstat_pkg;

  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 104;

  // request kinds carried in s_axis_tuser
  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_RTT   = 1'b1;

  localparam logic [15:0] LOSS_WINDOW_RST = 16'd2000;
  localparam logic [13:0] LOSS_SCALE      = 14'd10000;
  localparam logic [32:0] JIT_ROUND       = 33'd8;

  // quotient never exceeds 10000, so 14 quotient bits cover it
  localparam int DIV_STEPS = 14;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } fls_state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic mul;
    logic div_step;
    logic out_load;
  } fls_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } fls_sts_t;

endpackage

/* hw/rtl/frame_link_statistics_core.sv */
// channel  dir  bits  contents (low bit up)
// s_axis   in   160   tdata: arrival_ms, sender_timestamp, fragments_expected,
//                     fragments_received, payload_len, probe_request, rtt_timestamp
//                     tuser: req_type
// m_axis   out  104   tdata: jitter_q4, loss_hundredths, loss_updated,
//                     frag_per_frame, latency_ms, frame_complete, send_rtt
// cfg      in   16    loss_window_ms, written when cfg_we is high
//
// One transaction at a time: accept, an update step, then an output load; a
// frame report that closes a loss window with loss also runs one multiply
// and 14 steps of the serial loss divider between the update and the output load.
// rst is synchronous and clears all statistics; loss_window_ms returns to 2000.
// The output register holds the result while m_axis_tready is low; a stall
// there keeps the next transaction waiting in the output state.
module frame_link_statistics_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [15:0]                         cfg_wdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [flstat_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // see table above
  input  logic                                s_axis_tuser,  // req_type
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [flstat_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // see table above
);
  import flstat_pkg::*;

  fls_cmd_t cmd;
  fls_sts_t sts;

  flstat_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  flstat_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

/* hw/rtl/flstat_ctrl.sv */
module flstat_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  flstat_pkg::fls_sts_t sts,
  output flstat_pkg::fls_cmd_t cmd
);
  import flstat_pkg::*;

  fls_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.need_div ? ST_MUL : ST_OUT;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state == ST_EXEC)
    else $error("accepted transaction did not start execution");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten while held");

  a_div_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && sts.div_last |=> state == ST_OUT)
    else $error("division did not finish into output");

endmodule

/* hw/rtl/flstat_dp.sv */
module flstat_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [15:0]                           cfg_wdata,
  input  logic [flstat_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                  s_axis_tuser,
  output logic [flstat_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  flstat_pkg::fls_cmd_t                  cmd,
  output flstat_pkg::fls_sts_t                  sts
);
  import flstat_pkg::*;

  // input holding registers
  logic        in_req;
  logic [31:0] in_arr, in_snd, in_echo;
  logic [15:0] in_exp, in_rcv;
  logic [23:0] in_plen;
  logic        in_rtt;

  logic [15:0] loss_window;
  logic [31:0] prev_sender_ts, prev_arrival, jitter_acc;
  logic        have_arrival, window_open;
  logic [31:0] window_start, expected_sum, received_sum;
  logic [13:0] loss_value;
  logic [15:0] last_frag_count;
  logic [31:0] rtt_frame_ts, rtt_start, latency_value;

  logic        flag_upd, flag_cmp, flag_snd;

  logic [31:0] div_den, div_diff, div_rem;
  logic [13:0] div_q;
  logic [DIV_CNT_W-1:0] div_cnt;

  // combinational update terms
  logic [31:0] d, mag;
  logic [32:0] jrnd;
  logic [33:0] jsum;
  logic [31:0] jit_next;
  logic [32:0] exp_add, rcv_add;
  logic [31:0] exp_new, rcv_new;
  logic [31:0] win_start_eff, elapsed;
  logic        close, need_div;
  logic [31:0] rtt_elapsed, lat;
  logic [45:0] prod;
  logic [32:0] trial;
  logic        ge;
  logic [32:0] trial_sub;

  always_comb begin
    d    = (in_arr - prev_arrival) - (in_snd - prev_sender_ts);
    // two's complement negate also maps 0x80000000 to itself
    mag  = d[31] ? (~d + 32'd1) : d;
    jrnd = ({1'b0, jitter_acc} + JIT_ROUND) >> 4;
    jsum = {2'b00, jitter_acc} + {2'b00, mag} - {1'b0, jrnd};
    jit_next = (jsum[33:32] != 2'b00) ? 32'hFFFF_FFFF : jsum[31:0];

    exp_add = {1'b0, expected_sum} + {17'd0, in_exp};
    rcv_add = {1'b0, received_sum} + {17'd0, in_rcv};
    exp_new = exp_add[32] ? 32'hFFFF_FFFF : exp_add[31:0];
    rcv_new = rcv_add[32] ? 32'hFFFF_FFFF : rcv_add[31:0];

    win_start_eff = window_open ? window_start : in_arr;
    elapsed       = in_arr - win_start_eff;
    close         = elapsed > {16'd0, loss_window};
    need_div      = (in_req == REQ_FRAME) && close && (exp_new != 32'd0) &&
                    (rcv_new < exp_new);

    rtt_elapsed = in_arr - rtt_start;
    lat         = (in_echo - rtt_frame_ts) - {1'b0, rtt_elapsed[31:1]};

    prod = 46'(div_diff) * 46'(LOSS_SCALE);

    // restoring step: next numerator bit comes from the top of div_q
    trial     = {div_rem, div_q[13]};
    ge        = trial >= {1'b0, div_den};
    trial_sub = trial - {1'b0, div_den};
  end

  assign sts.need_div = need_div;
  assign sts.div_last = (div_cnt == '0);
  assign sts.out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_req  <= s_axis_tuser;
      in_arr  <= s_axis_tdata[31:0];
      in_snd  <= s_axis_tdata[63:32];
      in_exp  <= s_axis_tdata[79:64];
      in_rcv  <= s_axis_tdata[95:80];
      in_plen <= s_axis_tdata[119:96];
      in_rtt  <= s_axis_tdata[120];
      in_echo <= s_axis_tdata[152:121];
    end
    if (cmd.exec) begin
      flag_upd <= 1'b0;
      flag_cmp <= 1'b0;
      flag_snd <= 1'b0;
      if (in_req == REQ_FRAME) begin
        flag_upd <= close;
        flag_cmp <= (in_rcv == in_exp) && (in_plen != 24'd0);
        flag_snd <= in_rtt;
        div_den  <= exp_new;
        div_diff <= exp_new - rcv_new;
      end
    end
    if (cmd.mul) begin
      div_rem <= prod[45:14];
      div_q   <= prod[13:0];
      div_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
    end
    if (cmd.div_step) begin
      div_rem <= ge ? trial_sub[31:0] : trial[31:0];
      div_q   <= {div_q[12:0], ge};
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
    if (cmd.out_load) begin
      m_axis_tdata <= {7'd0, flag_snd, flag_cmp, latency_value, last_frag_count,
                       flag_upd, loss_value, jitter_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_window     <= LOSS_WINDOW_RST;
      prev_sender_ts  <= '0;
      prev_arrival    <= '0;
      have_arrival    <= 1'b0;
      jitter_acc      <= '0;
      window_start    <= '0;
      window_open     <= 1'b0;
      expected_sum    <= '0;
      received_sum    <= '0;
      loss_value      <= '0;
      last_frag_count <= '0;
      rtt_frame_ts    <= '0;
      rtt_start       <= '0;
      latency_value   <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        loss_window <= cfg_wdata;
      end
      if (cmd.exec) begin
        if (in_req == REQ_RTT) begin
          latency_value <= lat;
        end else begin
          if (have_arrival) begin
            jitter_acc <= jit_next;
          end
          prev_sender_ts  <= in_snd;
          prev_arrival    <= in_arr;
          have_arrival    <= 1'b1;
          window_open     <= 1'b1;
          last_frag_count <= in_exp;
          if (close) begin
            window_start <= in_arr;
            expected_sum <= '0;
            received_sum <= '0;
            if (!need_div) begin
              loss_value <= '0;
            end
          end else begin
            window_start <= win_start_eff;
            expected_sum <= exp_new;
            received_sum <= rcv_new;
          end
          if (in_rtt) begin
            rtt_frame_ts <= in_snd;
            rtt_start    <= in_arr;
          end
        end
      end
      if (cmd.div_step && sts.div_last) begin
        loss_value <= {div_q[12:0], ge};
      end
      if (cmd.out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> div_rem < div_den)
    else $error("divider remainder out of range");

  a_loss_bound: assert property (@(posedge clk) disable iff (rst)
    loss_value <= LOSS_SCALE)
    else $error("loss above 100 percent");

  a_closed_sums: assert property (@(posedge clk) disable iff (rst)
    !window_open |-> expected_sum == 32'd0 && received_sum == 32'd0)
    else $error("sums nonzero before window opened");

endmodule
